// File: design/brhp_pkg.sv
package brhp_pkg;

   // Width of the offsets and of the file size that the parser keeps.
   localparam int DEFAULT_OFFSET_BITS = 64;

   // Every header value must open with the text "bytes=".
   localparam int PREFIX_LEN = 6;
   localparam logic [7:0] PREFIX_CHARS [PREFIX_LEN] = '{
      8'h62,   // b
      8'h79,   // y
      8'h74,   // t
      8'h65,   // e
      8'h73,   // s
      8'h3D    // =
   };

   localparam logic [7:0] CHAR_DASH = 8'h2D;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   // Decimal radix of the offset numbers.
   localparam int RADIX = 10;

   // Width of the full-size fields on the ports.
   localparam int PORT_OFFSET_BITS = 64;

endpackage

// File: design/byte_range_header_parser_top.sv
// A header-ending request passes the snapshot and result registers before its result leaves.
// Throughput: one header byte per cycle, with no gap between headers, unless the output stalls.
// Requests that end no header produce no result; they only advance the parser state.
// Reset (synchronous, active high) clears the parser state, the pipeline valid bits
// and the file size register.
module byte_range_header_parser_top #(
   parameter int OFFSET_BITS = brhp_pkg::DEFAULT_OFFSET_BITS
) (
   input  logic         clock,
   input  logic         reset,

   // Header byte stream.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] header_byte
   input  logic         req_tlast,   // last character of the header
   input  logic [0:0]   req_tuser,   // [0] no_header

   // Parsed range results.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // [63:0] range_start, [127:64] range_end
   output logic [1:0]   rsp_tuser,   // [0] present, [1] valid_res

   // Register port: the file size register sits at byte address 0.
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [63:0]  csr_pwdata,
   output logic [63:0]  csr_prdata,
   output logic         csr_pready
);
   import brhp_pkg::*;

   localparam int NUM_W  = OFFSET_BITS;
   localparam int PROD_W = OFFSET_BITS + 4;

   // ------------------------------------------------------------------
   // Register port. Only the low OFFSET_BITS bits of the file size are
   // kept; reads return the stored value zero-extended.
   // ------------------------------------------------------------------
   logic [NUM_W-1:0] resource_size_ff;
   logic             csr_write;
   logic             csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[3] == 1'b0);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         resource_size_ff <= '0;
      end else if (csr_write && csr_hit) begin
         resource_size_ff <= csr_pwdata[NUM_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_hit) begin
         csr_prdata = PORT_OFFSET_BITS'(resource_size_ff);
      end
   end

   // ------------------------------------------------------------------
   // Handshake. A request is taken whenever the snapshot stage is empty
   // or will move into the result register in this cycle, so bytes keep
   // flowing while a finished result waits on the output side.
   // ------------------------------------------------------------------
   logic snap_valid_ff;
   logic rsp_valid_ff;
   logic snap_advance;
   logic req_accept;
   logic req_no_header;
   logic req_ends;

   assign snap_advance  = !rsp_valid_ff || rsp_tready;
   assign req_tready    = !snap_valid_ff || snap_advance;
   assign req_accept    = req_tvalid && req_tready;
   assign req_no_header = req_tuser[0];
   assign req_ends      = req_no_header || req_tlast;

   // ------------------------------------------------------------------
   // Parser state: prefix match, dash flag, two decimal accumulators.
   // ------------------------------------------------------------------
   logic [2:0]       prefix_ff;
   logic             dash_ff;
   logic [NUM_W-1:0] first_ff;
   logic [NUM_W-1:0] second_ff;
   logic             first_seen_ff;
   logic             second_seen_ff;
   logic             malformed_ff;

   // State after the current byte is applied.
   logic [2:0]        parse_prefix;
   logic              parse_dash;
   logic [NUM_W-1:0]  parse_first;
   logic [NUM_W-1:0]  parse_second;
   logic              parse_first_seen;
   logic              parse_second_seen;
   logic              parse_malformed;

   logic              in_prefix;
   logic              is_digit;
   logic [3:0]        digit;
   logic [NUM_W-1:0]  acc_sel;
   logic [PROD_W-1:0] acc_ext;
   logic [PROD_W-1:0] acc_next;
   logic              acc_overflow;

   assign in_prefix = (prefix_ff < 3'(PREFIX_LEN));
   assign is_digit  = (req_tdata inside {[CHAR_ZERO:CHAR_NINE]});
   assign digit     = 4'(req_tdata - CHAR_ZERO);

   // Multiply by ten as (acc << 3) + (acc << 1), then add the digit. Any
   // bit above the offset width means the number no longer fits.
   assign acc_sel      = dash_ff ? second_ff : first_ff;
   assign acc_ext      = PROD_W'(acc_sel);
   assign acc_next     = (acc_ext << 3) + (acc_ext << 1) + PROD_W'(digit);
   assign acc_overflow = |acc_next[PROD_W-1:NUM_W];

   always_comb begin
      parse_prefix      = prefix_ff;
      parse_dash        = dash_ff;
      parse_first       = first_ff;
      parse_second      = second_ff;
      parse_first_seen  = first_seen_ff;
      parse_second_seen = second_seen_ff;
      parse_malformed   = malformed_ff;
      if (!malformed_ff) begin
         if (in_prefix) begin
            if (req_tdata == PREFIX_CHARS[prefix_ff]) begin
               parse_prefix = prefix_ff + 3'd1;
            end else begin
               parse_malformed = 1'b1;
            end
         end else if (req_tdata == CHAR_DASH) begin
            // A second dash leaves the tail unparseable.
            if (dash_ff) begin
               parse_malformed = 1'b1;
            end else begin
               parse_dash = 1'b1;
            end
         end else if (is_digit) begin
            if (acc_overflow) begin
               parse_malformed = 1'b1;
            end
            if (dash_ff) begin
               parse_second      = acc_next[NUM_W-1:0];
               parse_second_seen = 1'b1;
            end else begin
               parse_first      = acc_next[NUM_W-1:0];
               parse_first_seen = 1'b1;
            end
         end else begin
            // Commas, spaces, signs and letters all make the header invalid.
            parse_malformed = 1'b1;
         end
      end
   end

   // Next state: cleared after every header, advanced by a middle byte.
   logic [2:0]       prefix_in;
   logic             dash_in;
   logic [NUM_W-1:0] first_in;
   logic [NUM_W-1:0] second_in;
   logic             first_seen_in;
   logic             second_seen_in;
   logic             malformed_in;

   always_comb begin
      prefix_in      = prefix_ff;
      dash_in        = dash_ff;
      first_in       = first_ff;
      second_in      = second_ff;
      first_seen_in  = first_seen_ff;
      second_seen_in = second_seen_ff;
      malformed_in   = malformed_ff;
      if (req_accept) begin
         if (req_ends) begin
            prefix_in      = '0;
            dash_in        = 1'b0;
            first_in       = '0;
            second_in      = '0;
            first_seen_in  = 1'b0;
            second_seen_in = 1'b0;
            malformed_in   = 1'b0;
         end else begin
            prefix_in      = parse_prefix;
            dash_in        = parse_dash;
            first_in       = parse_first;
            second_in      = parse_second;
            first_seen_in  = parse_first_seen;
            second_seen_in = parse_second_seen;
            malformed_in   = parse_malformed;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff      <= '0;
         dash_ff        <= 1'b0;
         first_ff       <= '0;
         second_ff      <= '0;
         first_seen_ff  <= 1'b0;
         second_seen_ff <= 1'b0;
         malformed_ff   <= 1'b0;
      end else begin
         prefix_ff      <= prefix_in;
         dash_ff        <= dash_in;
         first_ff       <= first_in;
         second_ff      <= second_in;
         first_seen_ff  <= first_seen_in;
         second_seen_ff <= second_seen_in;
         malformed_ff   <= malformed_in;
      end
   end

   // ------------------------------------------------------------------
   // Snapshot stage. The final parser state of a header is copied here so
   // that the parser can start on the next header in the very next cycle.
   // Prefix, dash and error checks collapse into a single bad flag.
   // ------------------------------------------------------------------
   logic             snap_load;
   logic             snap_valid_in;
   logic             snap_present_ff;
   logic             snap_bad_ff;
   logic             snap_first_seen_ff;
   logic             snap_second_seen_ff;
   logic [NUM_W-1:0] snap_first_ff;
   logic [NUM_W-1:0] snap_second_ff;

   assign snap_load = req_accept && req_ends;

   always_comb begin
      snap_valid_in = snap_valid_ff;
      if (snap_load) begin
         snap_valid_in = 1'b1;
      end else if (snap_advance) begin
         snap_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
      end else begin
         snap_valid_ff <= snap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (snap_load) begin
         snap_present_ff     <= !req_no_header;
         snap_bad_ff         <= parse_malformed || !parse_dash ||
                                (parse_prefix != 3'(PREFIX_LEN));
         snap_first_seen_ff  <= parse_first_seen;
         snap_second_seen_ff <= parse_second_seen;
         snap_first_ff       <= parse_first;
         snap_second_ff      <= parse_second;
      end
   end

   // ------------------------------------------------------------------
   // Range resolution. All compares and both subtracts work side by side
   // on the snapshot and the file size, and a final select picks the form.
   // ------------------------------------------------------------------
   logic [NUM_W-1:0] fs_m1;
   logic             fs_zero;
   logic             second_lt_fs;
   logic             first_lt_fs;
   logic             second_ge_first;
   logic [NUM_W-1:0] suffix_start;
   logic             fin_ok;
   logic             fin_valid;
   logic [NUM_W-1:0] fin_start;
   logic [NUM_W-1:0] fin_end;

   assign fs_m1           = resource_size_ff - NUM_W'(1);
   assign fs_zero         = (resource_size_ff == '0);
   assign second_lt_fs    = (snap_second_ff < resource_size_ff);
   assign first_lt_fs     = (snap_first_ff < resource_size_ff);
   assign second_ge_first = (snap_second_ff >= snap_first_ff);
   assign suffix_start    = second_lt_fs ? (resource_size_ff - snap_second_ff) : '0;

   always_comb begin
      if (!snap_first_seen_ff) begin
         // Suffix form: the last N bytes, the whole file if N is larger.
         fin_ok    = snap_second_seen_ff && (snap_second_ff != '0);
         fin_start = suffix_start;
         fin_end   = fs_m1;
      end else begin
         // Open form or explicit form, end clamped to the last byte.
         fin_ok    = first_lt_fs && (!snap_second_seen_ff || second_ge_first);
         fin_start = snap_first_ff;
         if (!snap_second_seen_ff || !second_lt_fs) begin
            fin_end = fs_m1;
         end else begin
            fin_end = snap_second_ff;
         end
      end
   end

   assign fin_valid = snap_present_ff && !snap_bad_ff && !fs_zero && fin_ok;

   // ------------------------------------------------------------------
   // Result register.
   // ------------------------------------------------------------------
   logic             rsp_valid_in;
   logic             rsp_present_ff;
   logic             rsp_ok_ff;
   logic [NUM_W-1:0] rsp_start_ff;
   logic [NUM_W-1:0] rsp_end_ff;

   assign rsp_valid_in = snap_advance ? snap_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (snap_advance && snap_valid_ff) begin
         rsp_present_ff <= snap_present_ff;
         rsp_ok_ff      <= fin_valid;
         rsp_start_ff   <= fin_valid ? fin_start : '0;
         rsp_end_ff     <= fin_valid ? fin_end : '0;
      end
   end

   assign rsp_tvalid            = rsp_valid_ff;
   assign rsp_tuser             = {rsp_ok_ff, rsp_present_ff};
   assign rsp_tdata[63:0]       = PORT_OFFSET_BITS'(rsp_start_ff);
   assign rsp_tdata[127:64]     = PORT_OFFSET_BITS'(rsp_end_ff);

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   a_valid_needs_present : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ok_ff |-> rsp_present_ff)
      else $error("valid range reported for an absent header");

   a_range_ordered : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ok_ff |-> (rsp_start_ff <= rsp_end_ff) &&
                                    (rsp_end_ff < resource_size_ff))
      else $error("reported range is reversed or past the end of the file");

   a_invalid_zeroed : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ok_ff |-> (rsp_start_ff == '0) && (rsp_end_ff == '0))
      else $error("invalid result carries nonzero offsets");

   a_state_cleared : assert property (@(posedge clock) disable iff (reset)
      req_accept && req_ends |=> (prefix_ff == '0) && !dash_ff && !malformed_ff &&
                                 !first_seen_ff && !second_seen_ff)
      else $error("parser state not cleared after a header ended");

   a_absent_snapshot : assert property (@(posedge clock) disable iff (reset)
      req_accept && req_no_header |=> snap_valid_ff && !snap_present_ff)
      else $error("absent header not captured in the snapshot stage");

   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> snap_valid_ff && rsp_valid_ff && !rsp_tready)
      else $error("request side stalled without a full pipeline");

endmodule

// File: dv/byte_range_header_parser_top_tb.sv
module byte_range_header_parser_top_tb;
   import brhp_pkg::*;

   // The parser is built at its default offset width, so the model keeps the same mask.
   localparam int OFFSET_BITS = DEFAULT_OFFSET_BITS;
   localparam logic [63:0] NUM_MASK = {64{1'b1}} >> (64 - OFFSET_BITS);

   // The file size register is the only register and sits at byte address 0.
   localparam logic [3:0] RESOURCE_SIZE_ADDR = 4'h0;

   // Characters that the stimulus uses to break headers on purpose.
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   // A result passes the snapshot and result registers after its request, so the slack
   // covers any header byte still in flight once the last result has shown up.
   localparam int DRAIN_SLACK = 8;
   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int RANDOM_REQUESTS = 270;

   // Receive-side readiness patterns; one is picked for each stretch of cycles.
   typedef enum int {
      READY_ALWAYS,
      READY_COIN,
      READY_PATTERN,
      READY_SPARSE
   } ready_mode_type;

   // One parsed range result, as the model predicts it.
   typedef struct packed {
      logic        present;
      logic        valid_res;
      logic [63:0] range_start;
      logic [63:0] range_end;
   } range_result_type;

   logic         clock;
   logic         reset;

   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;   // [7:0] header_byte
   logic         req_tlast;   // last character of the header
   logic [0:0]   req_tuser;   // [0] no_header

   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;   // [63:0] range_start, [127:64] range_end
   logic [1:0]   rsp_tuser;   // [0] present, [1] valid_res

   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [3:0]   csr_paddr;
   logic [63:0]  csr_pwdata;
   logic [63:0]  csr_prdata;
   logic         csr_pready;

   // Model copy of the configuration and of the parse state.
   logic [63:0]  model_resource_size;
   logic [2:0]   parse_prefix_count;
   logic         parse_after_dash;
   logic [63:0]  parse_first;
   logic [63:0]  parse_second;
   logic         parse_first_seen;
   logic         parse_second_seen;
   logic         parse_malformed;

   // Ranges predicted for accepted requests and not yet seen on the result side.
   range_result_type expected_ranges [$];
   range_result_type oldest_range;

   // Bytes of the header currently being built by the stimulus.
   logic [7:0]   hdr_bytes [$];

   int           requests_sent;
   int           mismatch_count;
   int           cycle_count;
   int           burst_left;
   bit           gaps_enabled;
   int           hold_off_left;
   int           ready_stretch_left;
   ready_mode_type ready_mode;

   // The clock runs from time zero with a period of 10 time units.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   byte_range_header_parser_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // The watchdog ends a run that hangs. Every correct run finishes far below this count.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("byte_range_header_parser_top_tb failed");
         $finish;
      end
   end

   // The result side changes its readiness at the falling edge. A long hold-off, when a
   // test asks for one, wins over the current pattern; otherwise a new pattern is drawn
   // for every stretch, and one of the patterns never stalls at all.
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         rsp_tready <= 1'b0;
         hold_off_left--;
      end else begin
         if (ready_stretch_left == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 3));
            ready_stretch_left = $urandom_range(20, 120);
         end
         ready_stretch_left--;
         case (ready_mode)
            READY_ALWAYS: rsp_tready <= 1'b1;
            READY_COIN: rsp_tready <= ($urandom_range(0, 1) == 1);
            READY_PATTERN: rsp_tready <= ((ready_stretch_left % 4) != 0);
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Every result taken at a rising edge is compared field by field with the oldest
   // predicted range. A result with nothing predicted is a failure too.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_ranges.size() == 0) begin
            $error("unexpected result: present %0b valid_res %0b start %0h end %0h",
                   rsp_tuser[0], rsp_tuser[1], rsp_tdata[63:0], rsp_tdata[127:64]);
            mismatch_count++;
         end else begin
            oldest_range = expected_ranges.pop_front();
            if (rsp_tuser[0] !== oldest_range.present) begin
               $error("present: expected %0b, got %0b", oldest_range.present, rsp_tuser[0]);
               mismatch_count++;
            end
            if (rsp_tuser[1] !== oldest_range.valid_res) begin
               $error("valid_res: expected %0b, got %0b",
                      oldest_range.valid_res, rsp_tuser[1]);
               mismatch_count++;
            end
            if (rsp_tdata[63:0] !== oldest_range.range_start) begin
               $error("range_start: expected %0d, got %0d",
                      oldest_range.range_start, rsp_tdata[63:0]);
               mismatch_count++;
            end
            if (rsp_tdata[127:64] !== oldest_range.range_end) begin
               $error("range_end: expected %0d, got %0d",
                      oldest_range.range_end, rsp_tdata[127:64]);
               mismatch_count++;
            end
         end
      end
   end

   function automatic void clear_parse_state();
      parse_prefix_count = '0;
      parse_after_dash = 1'b0;
      parse_first = '0;
      parse_second = '0;
      parse_first_seen = 1'b0;
      parse_second_seen = 1'b0;
      parse_malformed = 1'b0;
   endfunction

   // Appends one byte to the header under construction.
   function automatic void append_byte(logic [7:0] b);
      hdr_bytes.insert(hdr_bytes.size(), b);
   endfunction

   // Advances the model by one accepted request and predicts the range that a last
   // byte or an absent header produces.
   function automatic void track_request(logic [7:0] c, logic is_last, logic absent);
      range_result_type res;
      logic [63:0]   digit;
      logic [63:0]   start_off;
      logic [63:0]   end_off;
      logic [63:0]   suffix;
      logic          ok;
      res = '0;
      start_off = '0;
      end_off = '0;
      if (absent) begin
         clear_parse_state();
         expected_ranges.insert(expected_ranges.size(), res);
         return;
      end
      // Once a header is malformed, its remaining bytes are ignored.
      if (!parse_malformed) begin
         if (parse_prefix_count < PREFIX_LEN) begin
            if (c == PREFIX_CHARS[parse_prefix_count])
               parse_prefix_count++;
            else
               parse_malformed = 1'b1;
         end else if (c == CHAR_DASH) begin
            if (parse_after_dash)
               parse_malformed = 1'b1;
            else
               parse_after_dash = 1'b1;
         end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            digit = 64'(c - CHAR_ZERO);
            // An overflowing digit leaves the accumulator as it was.
            if (parse_after_dash) begin
               if (parse_second > (NUM_MASK - digit) / RADIX)
                  parse_malformed = 1'b1;
               else
                  parse_second = parse_second * RADIX + digit;
               parse_second_seen = 1'b1;
            end else begin
               if (parse_first > (NUM_MASK - digit) / RADIX)
                  parse_malformed = 1'b1;
               else
                  parse_first = parse_first * RADIX + digit;
               parse_first_seen = 1'b1;
            end
         end else begin
            parse_malformed = 1'b1;
         end
      end
      if (!is_last)
         return;
      ok = 1'b0;
      if (!parse_malformed && parse_prefix_count == PREFIX_LEN && parse_after_dash &&
          model_resource_size != 0) begin
         ok = 1'b1;
         if (!parse_first_seen) begin
            // Suffix form: the last N bytes, the whole file when N is larger.
            if (!parse_second_seen || parse_second == 0) begin
               ok = 1'b0;
            end else begin
               suffix = (parse_second < model_resource_size) ? parse_second :
                        model_resource_size;
               start_off = model_resource_size - suffix;
               end_off = model_resource_size - 1;
            end
         end else begin
            start_off = parse_first;
            end_off = parse_second_seen ? parse_second : model_resource_size - 1;
         end
         if (ok && (start_off >= model_resource_size || end_off < start_off))
            ok = 1'b0;
         if (ok && end_off > model_resource_size - 1)
            end_off = model_resource_size - 1;
      end
      res.present = 1'b1;
      res.valid_res = ok;
      res.range_start = ok ? start_off : '0;
      res.range_end = ok ? end_off : '0;
      expected_ranges.insert(expected_ranges.size(), res);
      clear_parse_state();
   endfunction

   function automatic logic [63:0] random_word();
      return {$urandom(), $urandom()};
   endfunction

   function automatic void push_decimal(logic [63:0] value);
      logic [7:0] digits [$];
      if (value == 0)
         digits.push_front(CHAR_ZERO);
      while (value != 0) begin
         digits.push_front(CHAR_ZERO + 8'(value % RADIX));
         value = value / RADIX;
      end
      foreach (digits[i])
         append_byte(digits[i]);
   endfunction

   function automatic void load_text(string text);
      for (int i = 0; i < text.len(); i++)
         append_byte(text[i]);
   endfunction

   // Offsets cluster around the file size so that the random headers hit the edges of
   // the satisfiable region, with some wide values and some that overflow.
   function automatic void push_offset();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
         append_byte(CHAR_ZERO + 8'($urandom_range(1, 9)));
         repeat ($urandom_range(19, 21))
            append_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
         return;
      end
      if (pick < 10)
         append_byte(CHAR_ZERO);
      case ($urandom_range(0, 7))
         0: push_decimal(64'd0);
         1: push_decimal(model_resource_size - 1);
         2: push_decimal(model_resource_size);
         3: push_decimal(model_resource_size + 1);
         4: push_decimal((model_resource_size == 0) ? 64'd0 :
                         random_word() % model_resource_size);
         5: push_decimal(64'($urandom_range(0, 50)));
         6: push_decimal(random_word());
         default: push_decimal({64{1'b1}});
      endcase
   endfunction

   // Mostly the exact "bytes=" prefix; now and then a cut or damaged copy of it.
   function automatic void push_prefix();
      int cut;
      cut = PREFIX_LEN;
      if ($urandom_range(0, 15) == 0)
         cut = $urandom_range(0, PREFIX_LEN - 1);
      for (int i = 0; i < cut; i++)
         append_byte(PREFIX_CHARS[i]);
      if ($urandom_range(0, 15) == 0 && cut > 0)
         hdr_bytes[$urandom_range(0, cut - 1)] = 8'($urandom_range(0, 255));
   endfunction

   // Sends one request. The sender works in bursts: before a new burst it may drop
   // valid for a random gap. Valid stays high after a handshake, so the caller must send
   // the next request at once or lower valid with stop_requests.
   task automatic send_request(logic [7:0] b, logic is_last, logic absent);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (gaps_enabled)
            gap = $urandom_range(0, 6);
      end
      burst_left--;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= is_last;
      req_tuser <= absent;
      do @(posedge clock); while (!req_tready);
      track_request(b, is_last, absent);
      requests_sent++;
   endtask

   task automatic stop_requests();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // The sender pauses until every predicted range has come back, then lets the
   // pipeline settle so that the parser is idle.
   task automatic drain_results();
      stop_requests();
      while (expected_ranges.size() != 0)
         @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   // Setup cycle, then access cycle; the register takes the value at the rising edge of
   // the access cycle, since pready is high.
   task automatic write_resource_size(logic [63:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= RESOURCE_SIZE_ADDR;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      model_resource_size = value & NUM_MASK;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Sends the bytes in hdr_bytes as one header, the final byte marked last.
   task automatic send_header_bytes();
      foreach (hdr_bytes[i])
         send_request(hdr_bytes[i], i == hdr_bytes.size() - 1, 1'b0);
   endtask

   task automatic send_text(string text);
      hdr_bytes.delete();
      load_text(text);
      send_header_bytes();
   endtask

   task automatic send_absent();
      send_request(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
   endtask

   // Straight after reset the file size is zero, so even a well-formed range is refused.
   task automatic test_reset_state();
      send_absent();
      send_text("bytes=0-0");
      send_text("bytes=-1");
      drain_results();
      write_resource_size(64'd0);
      send_text("bytes=5-");
      drain_results();
   endtask

   // The three range forms on a 1000-byte file, with clamping and the refusals that
   // come from the offsets alone.
   task automatic test_range_forms();
      write_resource_size(64'd1000);
      send_text("bytes=0-499");
      send_text("bytes=500-");
      send_text("bytes=-500");
      send_text("bytes=-2000");
      send_text("bytes=900-5000");
      send_text("bytes=999-999");
      send_text("bytes=1000-");
      send_text("bytes=5-3");
      send_text("bytes=-0");
      send_text("bytes=-");
      drain_results();
   endtask

   // Headers that break the grammar, including the lowest and highest byte codes.
   task automatic test_malformed_headers();
      send_text("bytes=5");
      send_text("bytes=1-2,3-4");
      send_text("bytes=1--2");
      send_text("bytes= 1-2");
      send_text("bytes=+1-2");
      send_text("bytex=1-2");
      send_text("byt");
      send_text("b");
      hdr_bytes.delete();
      append_byte(8'h00);
      load_text("bytes=1-2");
      send_header_bytes();
      hdr_bytes.delete();
      load_text("bytes=1-");
      append_byte(8'hFF);
      send_header_bytes();
      hdr_bytes.delete();
      load_text("bytes=1");
      append_byte(CHAR_COMMA);
      append_byte(CHAR_SPACE);
      load_text("-2");
      send_header_bytes();
      drain_results();
   endtask

   // Offsets at the edge of 64 bits, and the smallest file that can be served.
   task automatic test_offset_limits();
      write_resource_size({64{1'b1}});
      send_text("bytes=18446744073709551614-");
      send_text("bytes=18446744073709551615-");
      send_text("bytes=18446744073709551616-");
      send_text("bytes=0-18446744073709551615");
      send_text("bytes=-18446744073709551615");
      send_text("bytes=-99999999999999999999");
      drain_results();
      write_resource_size(64'd1);
      send_text("bytes=0-0");
      send_text("bytes=-1");
      send_text("bytes=1-");
      drain_results();
   endtask

   // An absent header in the middle of a header drops the bytes taken so far.
   task automatic test_absent_mid_header();
      write_resource_size(64'd50);
      hdr_bytes.delete();
      load_text("bytes=1");
      foreach (hdr_bytes[i])
         send_request(hdr_bytes[i], 1'b0, 1'b0);
      send_request(CHAR_DASH, 1'b1, 1'b1);
      send_text("bytes=2-3");
      send_absent();
      send_absent();
      drain_results();
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering
   // requests, so the parser fills up and has to stall its input.
   task automatic test_backpressure();
      write_resource_size(64'd4096);
      gaps_enabled = 1'b0;
      hold_off_left = LONG_HOLD_CYCLES;
      repeat (40)
         send_absent();
      repeat (6)
         send_text("bytes=-100");
      drain_results();
      gaps_enabled = 1'b1;
   endtask

   // One random header: mostly well-formed ranges with random offsets, the rest broken
   // forms and noise. Now and then the header is cut off by an absent request.
   task automatic send_random_header();
      int form;
      int cut;
      form = $urandom_range(0, 99);
      hdr_bytes.delete();
      if (form < 90)
         push_prefix();
      if (form < 30) begin
         push_offset();
         append_byte(CHAR_DASH);
         push_offset();
      end else if (form < 48) begin
         push_offset();
         append_byte(CHAR_DASH);
      end else if (form < 66) begin
         append_byte(CHAR_DASH);
         push_offset();
      end else if (form < 71) begin
         push_offset();
      end else if (form < 76) begin
         if ($urandom_range(0, 1) == 1)
            push_offset();
         append_byte(CHAR_DASH);
         append_byte(CHAR_DASH);
         push_offset();
      end else if (form < 83) begin
         push_offset();
         append_byte(CHAR_DASH);
         push_offset();
         append_byte(CHAR_COMMA);
         push_offset();
         append_byte(CHAR_DASH);
      end else if (form < 90) begin
         if ($urandom_range(0, 1) == 1)
            append_byte(CHAR_DASH);
      end else begin
         repeat ($urandom_range(1, 12))
            append_byte(8'($urandom_range(0, 255)));
      end
      if (hdr_bytes.size() == 0)
         append_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) == 0)
         hdr_bytes[$urandom_range(0, hdr_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      cut = hdr_bytes.size();
      if ($urandom_range(0, 19) == 0)
         cut = $urandom_range(0, hdr_bytes.size() - 1);
      for (int i = 0; i < cut; i++)
         send_request(hdr_bytes[i], i == hdr_bytes.size() - 1, 1'b0);
      if (cut < hdr_bytes.size())
         send_absent();
   endtask

   // Random phases, each with a fresh file size written while the parser is idle and
   // with or without sender gaps.
   task automatic test_random_headers();
      int goal;
      int size_pick;
      goal = requests_sent + RANDOM_REQUESTS;
      while (requests_sent < goal) begin
         size_pick = $urandom_range(0, 9);
         case (size_pick)
            0: write_resource_size(64'd0);
            1: write_resource_size(64'd1);
            2: write_resource_size({64{1'b1}});
            3: write_resource_size(random_word());
            4, 5: write_resource_size(64'($urandom_range(1, 200)));
            default: write_resource_size(64'($urandom_range(2, 100000)));
         endcase
         gaps_enabled = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(3, 8)) begin
            if ($urandom_range(0, 19) == 0)
               send_absent();
            else
               send_random_header();
         end
         drain_results();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      model_resource_size = '0;
      clear_parse_state();
      requests_sent = 0;
      mismatch_count = 0;
      cycle_count = 0;
      burst_left = 0;
      gaps_enabled = 1'b1;
      hold_off_left = 0;
      ready_stretch_left = 0;
      ready_mode = READY_ALWAYS;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_range_forms();
      test_malformed_headers();
      test_offset_limits();
      test_absent_mid_header();
      test_backpressure();
      test_random_headers();

      // Every predicted range has arrived and the pipeline has had time to settle;
      // anything left over would already have failed in the checker.
      drain_results();
      if (mismatch_count == 0)
         $display("byte_range_header_parser_top_tb passed");
      else
         $display("byte_range_header_parser_top_tb failed");
      $finish;
   end

endmodule

// File: byte_range_header_parser_top.f
design/brhp_pkg.sv
design/byte_range_header_parser_top.sv
dv/byte_range_header_parser_top_tb.sv
